FILE: rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int CMD_W          = 3;
  localparam int FRAC_W         = 5;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;
  localparam int DIV_STEPS      = 2 * DATA_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TO_FIXED  = 3'd0,
    CMD_TO_INT    = 3'd1,
    CMD_FRAC      = 3'd2,
    CMD_WHOLE     = 3'd3,
    CMD_MUL       = 3'd4,
    CMD_MUL_ROUND = 3'd5,
    CMD_DIV       = 3'd6
  } cmd_e;

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    KIND_DIRECT  = 2'd0,
    KIND_MUL     = 2'd1,
    KIND_MUL_RND = 2'd2,
    KIND_DIV     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FRAC_W-1:0]  frac;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  direct;
  } work_t;

  // low bits of the word width that fit into the result field
  function automatic logic [DATA_W-1:0] word_mask(input int width);
    logic [63:0] m;
    m = (width >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << width) - 64'd1);
    return m[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fpa_front.sv
`default_nettype none
module fpa_front #(
  parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [fpa_pkg::CMD_W-1:0]   in_cmd_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]  in_a_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]  in_b_i,
  input  wire logic [fpa_pkg::FRAC_W-1:0]  frac_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output fpa_pkg::work_t                   out_item_o
);

  localparam logic [fpa_pkg::DATA_W-1:0] WMASK = fpa_pkg::word_mask(WORD_WIDTH);

  logic                           valid_q;
  fpa_pkg::work_t                 item_q, item_d;
  logic [fpa_pkg::DATA_W-1:0]     a_m, fmask;

  // decode and work out the shift and mask commands right away
  always_comb begin
    a_m   = in_a_i & WMASK;
    fmask = (fpa_pkg::DATA_W'(1) << frac_i) - fpa_pkg::DATA_W'(1);
    item_d.frac   = frac_i;
    item_d.a      = a_m;
    item_d.b      = in_b_i & WMASK;
    item_d.kind   = fpa_pkg::KIND_DIRECT;
    item_d.direct = '0;
    case (in_cmd_i)
      fpa_pkg::CMD_TO_FIXED:  item_d.direct = (a_m << frac_i) & WMASK;
      fpa_pkg::CMD_TO_INT:    item_d.direct = a_m >> frac_i;
      fpa_pkg::CMD_FRAC:      item_d.direct = a_m & fmask;
      fpa_pkg::CMD_WHOLE:     item_d.direct = a_m & ~fmask;
      fpa_pkg::CMD_MUL:       item_d.kind   = fpa_pkg::KIND_MUL;
      fpa_pkg::CMD_MUL_ROUND: item_d.kind   = fpa_pkg::KIND_MUL_RND;
      fpa_pkg::CMD_DIV:       item_d.kind   = fpa_pkg::KIND_DIV;
      default:                item_d.direct = '0;
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fpa_fifo.sv
`default_nettype none
module fpa_fifo (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_ready_o,
  input  wire fpa_pkg::work_t wr_item_i,
  output logic          rd_valid_o,
  input  wire logic     rd_ready_i,
  output fpa_pkg::work_t rd_item_o
);

  fpa_pkg::work_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !rd_ready_i) |=> cnt_q == 2'd2)
    else $error("full queue lost an item");

endmodule
`default_nettype wire

FILE: rtl/fpa_exec.sv
`default_nettype none
module fpa_exec #(
  parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire fpa_pkg::work_t              in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [fpa_pkg::DATA_W-1:0]       out_result_o,
  output logic                             out_dz_o
);

  localparam int NS = fpa_pkg::DIV_STEPS + 1;
  localparam int DW = fpa_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam logic [DW-1:0] WMASK = fpa_pkg::word_mask(WORD_WIDTH);

  typedef struct packed {
    fpa_pkg::kind_e             kind;
    logic [fpa_pkg::FRAC_W-1:0] frac;
    logic [DW-1:0]              b;
    logic [DW-1:0]              direct;
    logic [DW-1:0]              rem;
    logic [PW-1:0]              dq;    // product, or dividend out / quotient in
  } stage_t;

  logic          valid_q [NS];
  stage_t        st_q    [NS];
  stage_t        st0_d;
  logic          advance;
  logic          out_valid_q, out_dz_q, out_dz_d;
  logic [DW-1:0] out_result_q, out_result_d;
  logic [PW-1:0] rnd, sum;
  stage_t        last;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // entry: one multiplier, or the shifted dividend
  always_comb begin
    st0_d.kind   = in_item_i.kind;
    st0_d.frac   = in_item_i.frac;
    st0_d.b      = in_item_i.b;
    st0_d.direct = in_item_i.direct;
    st0_d.rem    = '0;
    if (in_item_i.kind == fpa_pkg::KIND_MUL || in_item_i.kind == fpa_pkg::KIND_MUL_RND) begin
      st0_d.dq = PW'(in_item_i.a) * PW'(in_item_i.b);
    end else begin
      st0_d.dq = PW'(in_item_i.a) << in_item_i.frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) st_q[0] <= st0_d;
  end

  // one restoring divide step per stage
  for (genvar k = 0; k < NS - 1; k++) begin : g_step
    logic [DW:0] r33;
    logic        ge;
    stage_t      nx;
    always_comb begin
      r33 = {st_q[k].rem, st_q[k].dq[PW-1]};
      ge  = (r33 >= {1'b0, st_q[k].b});
      nx  = st_q[k];
      if (st_q[k].kind == fpa_pkg::KIND_DIV) begin
        nx.rem = ge ? DW'(r33 - {1'b0, st_q[k].b}) : r33[DW-1:0];
        nx.dq  = {st_q[k].dq[PW-2:0], ge};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (advance) begin
        valid_q[k+1] <= valid_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) st_q[k+1] <= nx;
    end
  end

  // finish: scale the product (rounding if asked), pick the quotient, or pass the direct result
  always_comb begin
    last = st_q[NS-1];
    rnd  = '0;
    if (last.kind == fpa_pkg::KIND_MUL_RND && last.frac != '0) begin
      rnd = PW'(1) << (last.frac - fpa_pkg::FRAC_W'(1));
    end
    sum          = last.dq + rnd;
    out_dz_d     = 1'b0;
    out_result_d = last.direct;
    case (last.kind)
      fpa_pkg::KIND_MUL, fpa_pkg::KIND_MUL_RND: out_result_d = DW'(sum >> last.frac) & WMASK;
      fpa_pkg::KIND_DIV: begin
        out_dz_d     = (last.b == '0);
        out_result_d = out_dz_d ? WMASK : (last.dq[DW-1:0] & WMASK);
      end
      default: out_result_d = last.direct;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= out_result_d;
      out_dz_q     <= out_dz_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_dz_o     = out_dz_q;

  a_dz_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dz_q) |-> (out_result_q == WMASK))
    else $error("zero divisor without all-ones result");
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> (valid_q[NS-1] == $past(valid_q[NS-1])))
    else $error("pipeline moved during stall");
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("entry open while output stalled");

endmodule
`default_nettype wire

FILE: rtl/fixed_point_alu.sv
// path from item accept to result valid: decode register, queue, multiplier or
//   dividend shift, 64 divide steps, output register
// throughput: one item per cycle while the output is not stalled; the 64-stage restoring divider sets the latency
// reset: rst_ni asynchronous active low, clears all valid bits; fraction_bits
//   returns to 16
`default_nettype none
module fixed_point_alu #(
  parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  wire logic [7:0]  s_axis_tuser,   // [2:0] command, rest zero
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result
  output logic [7:0]       m_axis_tuser,   // [0] divide_by_zero, rest zero
  // fraction_bits register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);

  logic [fpa_pkg::FRAC_W-1:0] frac_q;

  // front to queue, queue to back
  logic           fr_valid, fr_ready;
  fpa_pkg::work_t fr_item;
  logic           q_valid, q_ready;
  fpa_pkg::work_t q_item;
  logic [31:0]    result;
  logic           dz;

  // register writes are taken at any time; block is idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= fpa_pkg::FRAC_RESET;
    end else if (cfg_valid_i) begin
      frac_q <= cfg_data_i;
    end
  end

  // front: decode the command, apply word mask, do shift/mask commands
  fpa_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[2:0]),
    .in_a_i      (s_axis_tdata[31:0]),
    .in_b_i      (s_axis_tdata[63:32]),
    .frac_i      (frac_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  // two-entry queue decouples front stalls from back stalls
  fpa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // back: multiplier and pipelined divider, all items take the same path length
  fpa_exec #(.WORD_WIDTH(WORD_WIDTH)) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_item_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result),
    .out_dz_o     (dz)
  );

  assign m_axis_tdata = result;
  assign m_axis_tuser = {7'd0, dz};

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int WORD_WIDTH = 32;
  localparam int LATENCY = 67;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [fpa_pkg::CMD_W-1:0]  command;
    logic [fpa_pkg::DATA_W-1:0] operand_a;
    logic [fpa_pkg::DATA_W-1:0] operand_b;
  } alu_item_t;

  typedef struct packed {
    logic [fpa_pkg::DATA_W-1:0] result;
    logic                       divide_by_zero;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] operand_a, [63:32] operand_b
  logic [7:0] s_axis_tuser = '0;    // [2:0] command
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] result
  logic [7:0] m_axis_tuser;         // [0] divide_by_zero
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  fixed_point_alu #(.WORD_WIDTH(WORD_WIDTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // pending items, the fraction setting each one runs under, expected results
  alu_item_t   pending_items[$];
  alu_result_t expected_results[$];
  logic [4:0]  frac_setting = fpa_pkg::FRAC_RESET;

  int  errors = 0;
  int  accepted_items = 0;
  int  checked_results = 0;
  int  idle_cycles = 0;
  bit  no_idling = 1'b0;
  bit  cfg_pending = 1'b0;
  int  src_gap = 0;
  int  snk_gap = 0;

  // handshake state seen at the rising edge, for the falling-edge driver
  logic s_axis_tready_q = 1'b0;
  logic cfg_ready_q = 1'b0;

  // compute the fixed-point result at full precision, then cut to the word
  function automatic alu_result_t compute_fixed(alu_item_t it, logic [4:0] f);
    alu_result_t r;
    logic [127:0] a, b, p, fmask;
    a = it.operand_a;
    b = it.operand_b;
    fmask = (128'd1 << f) - 128'd1;
    r.divide_by_zero = 1'b0;
    p = '0;
    case (it.command)
      fpa_pkg::CMD_TO_FIXED:  p = a << f;
      fpa_pkg::CMD_TO_INT:    p = a >> f;
      fpa_pkg::CMD_FRAC:      p = a & fmask;
      fpa_pkg::CMD_WHOLE:     p = a & ~fmask;
      fpa_pkg::CMD_MUL:       p = (a * b) >> f;
      fpa_pkg::CMD_MUL_ROUND: p = (f == 0) ? a * b : (a * b + (128'd1 << (f - 1))) >> f;
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          p = '1;
          r.divide_by_zero = 1'b1;
        end else begin
          p = (a << f) / b;
        end
      end
      default:       p = '0;
    endcase
    r.result = p[fpa_pkg::DATA_W-1:0];
    return r;
  endfunction

  // driver: items leave the queue on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          alu_item_t it;
          it = pending_items.pop_front();
          s_axis_tdata <= {it.operand_b, it.operand_a};
          s_axis_tuser <= {5'd0, it.command};
          s_axis_tvalid <= 1'b1;
          if (!no_idling && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idling && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 3);
      end
      if (cfg_pending && cfg_valid_i && cfg_ready_q) begin
        cfg_valid_i <= 1'b0;
        cfg_pending <= 1'b0;
      end
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    cfg_ready_q <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (cfg_valid_i && cfg_ready_o) frac_setting <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        alu_item_t it;
        it.command = s_axis_tuser[2:0];
        it.operand_a = s_axis_tdata[31:0];
        it.operand_b = s_axis_tdata[63:32];
        expected_results.push_back(compute_fixed(it, frac_setting));
        accepted_items <= accepted_items + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        alu_result_t exp_r;
        checked_results <= checked_results + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h dz %b", $time, m_axis_tdata, m_axis_tuser[0]);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata !== exp_r.result || m_axis_tuser[0] !== exp_r.divide_by_zero) begin
            $display("%0t: expected result %h dz %b, got %h dz %b", $time,
                     exp_r.result, exp_r.divide_by_zero, m_axis_tdata, m_axis_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic alu_item_t rand_item(bit any_cmd);
    alu_item_t it;
    int pick;
    it.command = any_cmd ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 6));
    pick = $urandom_range(0, 9);
    it.operand_a = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd0 :
                   (pick < 5) ? 32'($urandom_range(0, 65535)) : $urandom;
    pick = $urandom_range(0, 9);
    it.operand_b = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                   (pick < 5) ? 32'($urandom_range(1, 65535)) : $urandom;
    return it;
  endfunction

  // sample at rising edges until every item has been sent and every result checked
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
  endtask

  // wait for every result, then for the pipeline to drain, then write the register
  task automatic write_fraction(logic [4:0] f);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i <= f;
    cfg_valid_i <= 1'b1;
    cfg_pending <= 1'b1;
    wait (!cfg_pending);
    @(negedge clk_i);
  endtask

  task automatic push_cmd(logic [2:0] c, logic [31:0] a, logic [31:0] b);
    alu_item_t it;
    it.command = c;
    it.operand_a = a;
    it.operand_b = b;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [4:0] settings[6];
    settings = '{5'd1, 5'd31, 5'd0, 5'd8, 5'd24, 5'd16};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every command at operand extremes, zero divisor, unused command
    push_cmd(fpa_pkg::CMD_TO_FIXED, 32'hFFFF_FFFF, 32'd0);
    push_cmd(fpa_pkg::CMD_TO_INT, 32'hFFFF_FFFF, 32'd0);
    push_cmd(fpa_pkg::CMD_FRAC, 32'hFFFF_FFFF, 32'd0);
    push_cmd(fpa_pkg::CMD_WHOLE, 32'hFFFF_FFFF, 32'd0);
    push_cmd(fpa_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(fpa_pkg::CMD_MUL_ROUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(fpa_pkg::CMD_MUL_ROUND, 32'h0000_8000, 32'd1);
    push_cmd(fpa_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'd0);
    push_cmd(fpa_pkg::CMD_DIV, 32'd0, 32'd0);
    push_cmd(fpa_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'd1);
    push_cmd(fpa_pkg::CMD_DIV, 32'd1, 32'hFFFF_FFFF);
    push_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(fpa_pkg::CMD_TO_FIXED, 32'd0, 32'hFFFF_FFFF);
    push_cmd(fpa_pkg::CMD_MUL, 32'd0, 32'd0);

    // random phases, one per fraction setting including the extremes
    foreach (settings[i]) begin
      write_fraction(settings[i]);
      for (int k = 0; k < 140; k++) pending_items.push_back(rand_item(k % 20 == 0));
      if (i == 5) no_idling = 1'b1;
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("ran %0d items over six fraction settings (0, 1, 8, 16, 24, 31), all commands",
             accepted_items);
    $display("checked %0d results including zero divisors and the unused command",
             checked_results);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
